// ----- rtl/blt_pkg.sv -----
package blt_pkg;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_WORD    = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_STRING  = 3'd3;
  localparam logic [2:0] MODE_ESCAPE  = 3'd4;
  localparam logic [2:0] MODE_OPEQ    = 3'd5;
  localparam logic [2:0] MODE_COMMENT = 3'd6;
  localparam logic [2:0] MODE_DROP    = 3'd7;

  localparam logic [1:0] KIND_TOKEN    = 2'd0;
  localparam logic [1:0] KIND_LINE_OK  = 2'd1;
  localparam logic [1:0] KIND_LINE_ERR = 2'd2;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;

  localparam logic [1:0] CLASS_WORD   = 2'd0;
  localparam logic [1:0] CLASS_NUMBER = 2'd1;
  localparam logic [1:0] CLASS_STRING = 2'd2;
  localparam logic [1:0] CLASS_SIGN   = 2'd3;

  localparam logic [1:0] ERR_TWO_DOTS   = 2'd0;
  localparam logic [1:0] ERR_BAD_ESCAPE = 2'd1;
  localparam logic [1:0] ERR_OPEN_STR   = 2'd2;
  localparam logic [1:0] ERR_BAD_CHAR   = 2'd3;

  localparam int TDATA_OUT_W = 16;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [1:0] token_class;
    logic       token_start;
    logic [7:0] token_byte;
    logic [1:0] error_code;
  } res_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       dot;
    res_t       res;
  } lex_t;

endpackage

// ----- rtl/basic_line_tokenizer_top.sv -----
// Line tokenizer: one source byte per transaction in, at most one tagged token byte,
// line status or line error out. It sustains one input transaction per clock while the
// output is ready; the input holds off only while a result waits on a stalled output
// and the input register is also full. Each byte passes the input register, one lexer step
// and the result register. Bytes that make no result (blanks, comments, closing quotes,
// backslashes inside strings, dropped bytes) pass silently.
module basic_line_tokenizer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,  // [7:0] ch
  input  logic                               in_tlast,  // line_end
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [blt_pkg::TDATA_OUT_W-1:0]    out_tdata, // [1:0] token_class, [2] token_start,
                                                        // [10:3] token_byte, [12:11] error_code
  output logic [1:0]                         out_tuser  // [1:0] kind
);

  logic          s1_v_r;
  logic [7:0]    s1_ch_r;
  logic          s1_eol_r;
  logic [2:0]    mode_r;
  logic          dot_r;
  logic          out_v_r;
  blt_pkg::res_t res_r;
  blt_pkg::lex_t lex_nxt;
  logic          adv;

  assign adv       = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || adv;

  blt_lexer u_lexer (
    .ch       (s1_ch_r),
    .line_end (s1_eol_r),
    .mode     (mode_r),
    .dot      (dot_r),
    .nxt      (lex_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      mode_r  <= blt_pkg::MODE_IDLE;
      dot_r   <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_v_r   <= 1'b1;
        s1_ch_r  <= in_tdata;
        s1_eol_r <= in_tlast;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        mode_r  <= lex_nxt.mode;
        dot_r   <= lex_nxt.dot;
        out_v_r <= lex_nxt.res.valid;
        res_r   <= lex_nxt.res;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {3'b000, res_r.error_code, res_r.token_byte,
                       res_r.token_start, res_r.token_class};

endmodule

// ----- rtl/blt_lexer.sv -----
module blt_lexer (
  input  logic [7:0]   ch,
  input  logic         line_end,
  input  logic [2:0]   mode,
  input  logic         dot,
  output blt_pkg::lex_t nxt
);

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return c == 8'h2b || c == 8'h2d || c == 8'h2a || c == 8'h2f || c == 8'h5e ||
           c == 8'h28 || c == 8'h29 || c == 8'h21 || c == 8'h5c || c == 8'h3c ||
           c == 8'h3e || c == 8'h3d || c == 8'h2c || c == 8'h3b || c == 8'h5f;
  endfunction

  function automatic blt_pkg::res_t tok(input logic [1:0] cls, input logic start,
                                        input logic [7:0] b);
    blt_pkg::res_t r;
    r = '0;
    r.valid       = 1'b1;
    r.kind        = blt_pkg::KIND_TOKEN;
    r.token_class = cls;
    r.token_start = start;
    r.token_byte  = b;
    return r;
  endfunction

  function automatic blt_pkg::res_t err(input logic [1:0] kind, input logic [1:0] code);
    blt_pkg::res_t r;
    r = '0;
    r.valid      = 1'b1;
    r.kind       = kind;
    r.error_code = code;
    return r;
  endfunction

  function automatic blt_pkg::lex_t fresh(input logic [7:0] c, input logic d);
    blt_pkg::lex_t f;
    f.mode = blt_pkg::MODE_IDLE;
    f.dot  = d;
    f.res  = '0;
    if (c == 8'h20 || c == 8'h09) begin
      f.mode = blt_pkg::MODE_IDLE;
    end else if (is_alpha(c)) begin
      f.mode = blt_pkg::MODE_WORD;
      f.res  = tok(blt_pkg::CLASS_WORD, 1'b1, c);
    end else if (is_digit(c)) begin
      f.mode = blt_pkg::MODE_NUMBER;
      f.dot  = 1'b0;
      f.res  = tok(blt_pkg::CLASS_NUMBER, 1'b1, c);
    end else if (c == 8'h22) begin
      f.mode = blt_pkg::MODE_STRING;
      f.res  = tok(blt_pkg::CLASS_STRING, 1'b1, c);
    end else if (c == 8'h3c || c == 8'h3e || c == 8'h21) begin
      f.mode = blt_pkg::MODE_OPEQ;
      f.res  = tok(blt_pkg::CLASS_SIGN, 1'b1, c);
    end else if (is_sign(c)) begin
      f.mode = blt_pkg::MODE_IDLE;
      f.res  = tok(blt_pkg::CLASS_SIGN, 1'b1, c);
    end else if (c == 8'h27) begin
      f.mode = blt_pkg::MODE_COMMENT;
    end else begin
      f.mode = blt_pkg::MODE_DROP;
      f.res  = err(blt_pkg::KIND_LINE_ERR, blt_pkg::ERR_BAD_CHAR);
    end
    return f;
  endfunction

  always_comb begin
    nxt.mode = mode;
    nxt.dot  = dot;
    nxt.res  = '0;
    if (line_end) begin
      nxt.mode = blt_pkg::MODE_IDLE;
      nxt.dot  = 1'b0;
      case (mode)
        blt_pkg::MODE_DROP:   nxt.res = '0;
        blt_pkg::MODE_STRING: nxt.res = err(blt_pkg::KIND_LINE_ERR, blt_pkg::ERR_OPEN_STR);
        blt_pkg::MODE_ESCAPE: nxt.res = err(blt_pkg::KIND_LINE_ERR, blt_pkg::ERR_BAD_ESCAPE);
        default:              nxt.res = err(blt_pkg::KIND_LINE_OK, blt_pkg::ERR_TWO_DOTS);
      endcase
    end else begin
      case (mode)
        blt_pkg::MODE_DROP, blt_pkg::MODE_COMMENT: begin
          nxt.res = '0;
        end
        blt_pkg::MODE_WORD: begin
          if (is_alpha(ch) || is_digit(ch)) begin
            nxt.res = tok(blt_pkg::CLASS_WORD, 1'b0, ch);
          end else begin
            nxt = fresh(ch, dot);
          end
        end
        blt_pkg::MODE_NUMBER: begin
          if (is_digit(ch)) begin
            nxt.res = tok(blt_pkg::CLASS_NUMBER, 1'b0, ch);
          end else if (ch == 8'h2e) begin
            if (dot) begin
              nxt.mode = blt_pkg::MODE_DROP;
              nxt.res  = err(blt_pkg::KIND_LINE_ERR, blt_pkg::ERR_TWO_DOTS);
            end else begin
              nxt.dot = 1'b1;
              nxt.res = tok(blt_pkg::CLASS_NUMBER, 1'b0, ch);
            end
          end else begin
            nxt = fresh(ch, dot);
          end
        end
        blt_pkg::MODE_STRING: begin
          if (ch == 8'h22) begin
            nxt.mode = blt_pkg::MODE_IDLE;
          end else if (ch == 8'h5c) begin
            nxt.mode = blt_pkg::MODE_ESCAPE;
          end else begin
            nxt.res = tok(blt_pkg::CLASS_STRING, 1'b0, ch);
          end
        end
        blt_pkg::MODE_ESCAPE: begin
          nxt.mode = blt_pkg::MODE_STRING;
          if (ch == 8'h6e) begin
            nxt.res = tok(blt_pkg::CLASS_STRING, 1'b0, 8'h0a);
          end else if (ch == 8'h74) begin
            nxt.res = tok(blt_pkg::CLASS_STRING, 1'b0, 8'h09);
          end else if (ch == 8'h5c || ch == 8'h22) begin
            nxt.res = tok(blt_pkg::CLASS_STRING, 1'b0, ch);
          end else begin
            nxt.mode = blt_pkg::MODE_DROP;
            nxt.res  = err(blt_pkg::KIND_LINE_ERR, blt_pkg::ERR_BAD_ESCAPE);
          end
        end
        blt_pkg::MODE_OPEQ: begin
          if (ch == 8'h3d) begin
            nxt.mode = blt_pkg::MODE_IDLE;
            nxt.res  = tok(blt_pkg::CLASS_SIGN, 1'b0, ch);
          end else begin
            nxt = fresh(ch, dot);
          end
        end
        default: begin
          nxt = fresh(ch, dot);
        end
      endcase
    end
  end

endmodule

// ----- rtl/blt_checker.sv -----
module blt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [blt_pkg::TDATA_OUT_W-1:0] out_tdata,
  input logic [1:0]                      out_tuser
);

  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != blt_pkg::KIND_UNUSED && out_tdata[15:13] == 3'b000)
    else $error("bad result kind or padding");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == blt_pkg::KIND_TOKEN |-> out_tdata[12:11] == 2'b00)
    else $error("token carries error code");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != blt_pkg::KIND_TOKEN |-> out_tdata[10:0] == 11'd0 &&
    (out_tuser == blt_pkg::KIND_LINE_ERR || out_tdata[12:11] == 2'b00))
    else $error("line status carries token fields");

endmodule

bind basic_line_tokenizer_top blt_checker u_blt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- tb/sv/basic_line_tokenizer_top_tb.sv -----
module basic_line_tokenizer_top_tb;

  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TARGET_ITEMS = 500;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] cls;
    logic       first;
    logic [7:0] chr;
    logic [1:0] err;
  } lex_out_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
    logic       typed;
    lex_out_t   want;
  } dir_row_t;

  localparam lex_out_t NO_WANT = '0;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic [7:0]                      in_tdata   = '0;
  logic                            in_tlast   = 1'b0;
  logic                            out_tready = 1'b0;
  logic                            in_tready;
  logic                            out_tvalid;
  logic [blt_pkg::TDATA_OUT_W-1:0] out_tdata;  // [1:0] token_class, [2] token_start,
                                               // [10:3] token_byte, [12:11] error_code
  logic [1:0]                      out_tuser;  // [1:0] kind

  logic [2:0]   lx_mode = blt_pkg::MODE_IDLE;
  logic         lx_dot  = 1'b0;
  lex_out_t     lex_exp_q[$];
  logic [8:0]   line_q[$];
  int           n_fail       = 0;
  int           n_sent       = 0;
  int           tx_idle_pct  = 0;
  int           rx_stall_pct = 0;
  int           hold_left    = 0;
  int           quiet        = 0;
  logic         hold_req     = 1'b0;
  logic         hold_done    = 1'b0;
  lex_out_t     seen;
  lex_out_t     oldest;
  dir_row_t     dir_tab[28];

  basic_line_tokenizer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] sign_char(int i);
    case (i)
      0:       return "+";
      1:       return "-";
      2:       return "*";
      3:       return "/";
      4:       return "^";
      5:       return "(";
      6:       return ")";
      7:       return "!";
      8:       return "\\";
      9:       return "<";
      10:      return ">";
      11:      return "=";
      12:      return ",";
      13:      return ";";
      default: return "_";
    endcase
  endfunction

  function automatic bit is_sign(logic [7:0] c);
    for (int i = 0; i < 15; i++) begin
      if (sign_char(i) == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic lex_out_t tok(logic [1:0] cls, logic first, logic [7:0] chr);
    lex_out_t r;
    r = '0;
    r.kind  = blt_pkg::KIND_TOKEN;
    r.cls   = cls;
    r.first = first;
    r.chr   = chr;
    return r;
  endfunction

  function automatic lex_out_t line_err(logic [1:0] err);
    lex_out_t r;
    r = '0;
    r.kind = blt_pkg::KIND_LINE_ERR;
    r.err  = err;
    return r;
  endfunction

  function automatic lex_out_t line_ok();
    lex_out_t r;
    r = '0;
    r.kind = blt_pkg::KIND_LINE_OK;
    return r;
  endfunction

  task automatic lex_fresh(input logic [7:0] c, output bit got, output lex_out_t r);
    got = 1'b1;
    r   = '0;
    if (c == " " || c == "\t") begin
      lx_mode = blt_pkg::MODE_IDLE;
      got     = 1'b0;
    end else if (is_letter(c)) begin
      lx_mode = blt_pkg::MODE_WORD;
      r       = tok(blt_pkg::CLASS_WORD, 1'b1, c);
    end else if (is_num(c)) begin
      lx_mode = blt_pkg::MODE_NUMBER;
      lx_dot  = 1'b0;
      r       = tok(blt_pkg::CLASS_NUMBER, 1'b1, c);
    end else if (c == "\"") begin
      lx_mode = blt_pkg::MODE_STRING;
      r       = tok(blt_pkg::CLASS_STRING, 1'b1, c);
    end else if (c == "<" || c == ">" || c == "!") begin
      lx_mode = blt_pkg::MODE_OPEQ;
      r       = tok(blt_pkg::CLASS_SIGN, 1'b1, c);
    end else if (is_sign(c)) begin
      lx_mode = blt_pkg::MODE_IDLE;
      r       = tok(blt_pkg::CLASS_SIGN, 1'b1, c);
    end else if (c == "'") begin
      lx_mode = blt_pkg::MODE_COMMENT;
      got     = 1'b0;
    end else begin
      lx_mode = blt_pkg::MODE_DROP;
      r       = line_err(blt_pkg::ERR_BAD_CHAR);
    end
  endtask

  task automatic lex_step(input logic [7:0] c, input logic e, output bit got,
                          output lex_out_t r);
    logic [2:0] mode;
    mode = lx_mode;
    got  = 1'b1;
    r    = '0;
    if (e) begin
      lx_mode = blt_pkg::MODE_IDLE;
      lx_dot  = 1'b0;
      case (mode)
        blt_pkg::MODE_DROP:   got = 1'b0;
        blt_pkg::MODE_STRING: r = line_err(blt_pkg::ERR_OPEN_STR);
        blt_pkg::MODE_ESCAPE: r = line_err(blt_pkg::ERR_BAD_ESCAPE);
        default:              r = line_ok();
      endcase
    end else begin
      case (mode)
        blt_pkg::MODE_DROP, blt_pkg::MODE_COMMENT: got = 1'b0;
        blt_pkg::MODE_WORD: begin
          if (is_letter(c) || is_num(c)) r = tok(blt_pkg::CLASS_WORD, 1'b0, c);
          else lex_fresh(c, got, r);
        end
        blt_pkg::MODE_NUMBER: begin
          if (is_num(c)) begin
            r = tok(blt_pkg::CLASS_NUMBER, 1'b0, c);
          end else if (c == ".") begin
            if (lx_dot) begin
              lx_mode = blt_pkg::MODE_DROP;
              r       = line_err(blt_pkg::ERR_TWO_DOTS);
            end else begin
              lx_dot = 1'b1;
              r      = tok(blt_pkg::CLASS_NUMBER, 1'b0, c);
            end
          end else begin
            lex_fresh(c, got, r);
          end
        end
        blt_pkg::MODE_STRING: begin
          if (c == "\"") begin
            lx_mode = blt_pkg::MODE_IDLE;
            got     = 1'b0;
          end else if (c == "\\") begin
            lx_mode = blt_pkg::MODE_ESCAPE;
            got     = 1'b0;
          end else begin
            r = tok(blt_pkg::CLASS_STRING, 1'b0, c);
          end
        end
        blt_pkg::MODE_ESCAPE: begin
          lx_mode = blt_pkg::MODE_STRING;
          if (c == "n") r = tok(blt_pkg::CLASS_STRING, 1'b0, 8'h0a);
          else if (c == "t") r = tok(blt_pkg::CLASS_STRING, 1'b0, 8'h09);
          else if (c == "\\" || c == "\"") r = tok(blt_pkg::CLASS_STRING, 1'b0, c);
          else begin
            lx_mode = blt_pkg::MODE_DROP;
            r       = line_err(blt_pkg::ERR_BAD_ESCAPE);
          end
        end
        blt_pkg::MODE_OPEQ: begin
          if (c == "=") begin
            lx_mode = blt_pkg::MODE_IDLE;
            r       = tok(blt_pkg::CLASS_SIGN, 1'b0, c);
          end else begin
            lex_fresh(c, got, r);
          end
        end
        default: lex_fresh(c, got, r);
      endcase
    end
  endtask

  task automatic send_item(input logic [7:0] c, input logic e, input bit typed,
                           input lex_out_t want);
    bit         got;
    lex_out_t   r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= e;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lex_step(c, e, got, r);
    if (typed) lex_exp_q.insert(lex_exp_q.size(), want);
    else if (got) lex_exp_q.insert(lex_exp_q.size(), r);
    n_sent++;
  endtask

  function automatic void put_ch(logic [7:0] c);
    line_q.insert(line_q.size(), {1'b0, c});
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1) == 0) return 8'("a" + $urandom_range(25));
    return 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  function automatic void add_token();
    logic [7:0] c;
    case ($urandom_range(9))
      0, 1: begin
        put_ch(rand_letter());
        repeat ($urandom_range(5)) put_ch($urandom_range(2) == 0 ? rand_digit() : rand_letter());
      end
      2, 3: begin
        put_ch(rand_digit());
        repeat ($urandom_range(5)) put_ch($urandom_range(9) == 0 ? 8'(".") : rand_digit());
      end
      4, 5: begin
        put_ch("\"");
        repeat ($urandom_range(6)) begin
          if ($urandom_range(9) < 2) begin
            put_ch("\\");
            case ($urandom_range(4))
              0:       put_ch("n");
              1:       put_ch("t");
              2:       put_ch("\\");
              3:       put_ch("\"");
              default: put_ch(8'($urandom_range(255)));
            endcase
          end else begin
            c = 8'($urandom_range(126, 32));
            put_ch((c == "\"" || c == "\\") ? 8'("a") : c);
          end
        end
        if ($urandom_range(6) != 0) put_ch("\"");
      end
      6, 7: begin
        c = sign_char(int'($urandom_range(14)));
        put_ch(c);
        if ((c == "<" || c == ">" || c == "!") && $urandom_range(1) == 1) put_ch("=");
      end
      8: begin
        put_ch("'");
        repeat ($urandom_range(4)) put_ch(8'($urandom_range(255)));
      end
      default: put_ch(8'($urandom_range(255)));
    endcase
    case ($urandom_range(5))
      0:       ;
      1:       put_ch("\t");
      default: put_ch(" ");
    endcase
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.kind  = out_tuser;
      seen.cls   = out_tdata[1:0];
      seen.first = out_tdata[2];
      seen.chr   = out_tdata[10:3];
      seen.err   = out_tdata[12:11];
      if (lex_exp_q.size() == 0) begin
        $error("kind: expected none, actual %0d", seen.kind);
        n_fail++;
      end else begin
        oldest = lex_exp_q.pop_front();
        check_field("kind", int'(oldest.kind), int'(seen.kind));
        check_field("token_class", int'(oldest.cls), int'(seen.cls));
        check_field("token_start", int'(oldest.first), int'(seen.first));
        check_field("token_byte", int'(oldest.chr), int'(seen.chr));
        check_field("error_code", int'(oldest.err), int'(seen.err));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int line_no;
    dir_tab = '{
      '{8'h00, 1'b1, 1'b1, line_ok()},
      '{"A",   1'b0, 1'b1, tok(blt_pkg::CLASS_WORD, 1'b1, "A")},
      '{"z",   1'b0, 1'b0, NO_WANT},
      '{"9",   1'b0, 1'b0, NO_WANT},
      '{"\t",  1'b0, 1'b0, NO_WANT},
      '{"0",   1'b0, 1'b1, tok(blt_pkg::CLASS_NUMBER, 1'b1, "0")},
      '{".",   1'b0, 1'b0, NO_WANT},
      '{".",   1'b0, 1'b1, line_err(blt_pkg::ERR_TWO_DOTS)},
      '{8'hff, 1'b0, 1'b0, NO_WANT},
      '{8'hff, 1'b1, 1'b0, NO_WANT},
      '{"\"",  1'b0, 1'b1, tok(blt_pkg::CLASS_STRING, 1'b1, "\"")},
      '{"\\",  1'b0, 1'b0, NO_WANT},
      '{"n",   1'b0, 1'b0, NO_WANT},
      '{"\\",  1'b0, 1'b0, NO_WANT},
      '{"\"",  1'b0, 1'b0, NO_WANT},
      '{"\"",  1'b0, 1'b0, NO_WANT},
      '{"<",   1'b0, 1'b0, NO_WANT},
      '{"=",   1'b0, 1'b0, NO_WANT},
      '{"'",   1'b0, 1'b0, NO_WANT},
      '{8'h80, 1'b0, 1'b0, NO_WANT},
      '{8'h00, 1'b1, 1'b1, line_ok()},
      '{8'hff, 1'b0, 1'b1, line_err(blt_pkg::ERR_BAD_CHAR)},
      '{8'h00, 1'b1, 1'b0, NO_WANT},
      '{"\"",  1'b0, 1'b0, NO_WANT},
      '{"\\",  1'b0, 1'b0, NO_WANT},
      '{8'h00, 1'b1, 1'b1, line_err(blt_pkg::ERR_BAD_ESCAPE)},
      '{"\"",  1'b0, 1'b0, NO_WANT},
      '{8'hff, 1'b1, 1'b1, line_err(blt_pkg::ERR_OPEN_STR)}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_item(dir_tab[i].ch, dir_tab[i].eol, dir_tab[i].typed,
                                   dir_tab[i].want);

    line_no = 0;
    while (n_sent < TARGET_ITEMS) begin
      case ((line_no / 8) % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 56; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 56; end
        default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
      endcase
      if (n_sent >= TARGET_ITEMS / 2 && !hold_req) hold_req <= 1'b1;
      repeat ($urandom_range(5, 1)) add_token();
      line_q.insert(line_q.size(), {1'b1, 8'($urandom_range(255))});
      while (line_q.size() != 0) begin
        logic [8:0] it;
        it = line_q.pop_front();
        send_item(it[7:0], it[8], 1'b0, NO_WANT);
      end
      line_no++;
    end

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (lex_exp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
